// ===== rtl/echo_count_to_range_and_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the echo count to range and ASCII block
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ECHO_COUNT_TO_RANGE_AND_ASCII_ASSERT_SVH
`define ECHO_COUNT_TO_RANGE_AND_ASCII_ASSERT_SVH

// General property on the block clock, disabled while reset is asserted.
`define ECR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Boolean that must hold whenever a result is offered on the output channel.
`define ECR_ASSERT_VALID(lbl, cond, msg) \
    `ECR_ASSERT_RST(lbl, out_valid |-> (cond), msg)

`endif

// ===== rtl/ecr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecr_pkg
// Widths, constants and codes shared by the echo range block and its checker.
// ----------------------------------------------------------------------------
package ecr_pkg;

    // Field widths.
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned DIST_W   = 16;
    localparam int unsigned CLS_W    = 2;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned PROD_W   = 27;
    localparam int unsigned INT_W    = 10;
    localparam int unsigned FRAC_W   = 6;

    // Pipeline depth, output register included.
    localparam int unsigned NUM_STAGES = 7;

    // Count to Q10.6 centimetres: (count * 0x0464) >> 10.
    localparam logic [PROD_W-1:0] SCALE       = 27'h0000464;
    localparam int unsigned       SCALE_SHIFT = 10;

    // Range class codes.
    localparam logic [CLS_W-1:0] CLS_COLLISION = 2'd0;
    localparam logic [CLS_W-1:0] CLS_IN_RANGE  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_ABOVE     = 2'd2;

    // ASCII characters used in the text.
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;

    // Configuration port.
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic        REG_MIN_RANGE = 1'b0;
    localparam logic        REG_MAX_RANGE = 1'b1;
    localparam logic [DIST_W-1:0] MIN_RANGE_RST = 16'd128;
    localparam logic [DIST_W-1:0] MAX_RANGE_RST = 16'd25600;

endpackage

// ===== rtl/ecr_in_if.sv =====
// ----------------------------------------------------------------------------
// ecr_in_if
// Input channel: one echo pulse count per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ecr_in_if;

    logic                       valid;
    logic                       ready;
    logic [ecr_pkg::CNT_W-1:0]  echo_count;

    modport source (output valid, output echo_count, input ready);
    modport sink   (input valid, input echo_count, output ready);

endinterface

// ===== rtl/ecr_out_if.sv =====
// ----------------------------------------------------------------------------
// ecr_out_if
// Output channel: distance, range class and six text characters per transfer.
// ----------------------------------------------------------------------------
interface ecr_out_if;

    logic                        valid;
    logic                        ready;
    logic [ecr_pkg::DIST_W-1:0]  distance_q10_6;
    logic [ecr_pkg::CLS_W-1:0]   range_class;
    logic [ecr_pkg::CHAR_W-1:0]  char_0;
    logic [ecr_pkg::CHAR_W-1:0]  char_1;
    logic [ecr_pkg::CHAR_W-1:0]  char_2;
    logic [ecr_pkg::CHAR_W-1:0]  char_3;
    logic [ecr_pkg::CHAR_W-1:0]  char_4;
    logic [ecr_pkg::CHAR_W-1:0]  char_5;

    modport source (
        output valid, output distance_q10_6, output range_class,
        output char_0, output char_1, output char_2,
        output char_3, output char_4, output char_5,
        input  ready
    );
    modport sink (
        input  valid, input distance_q10_6, input range_class,
        input  char_0, input char_1, input char_2,
        input  char_3, input char_4, input char_5,
        output ready
    );

endinterface

// ===== rtl/echo_count_to_range_and_ascii.sv =====
// ----------------------------------------------------------------------------
// echo_count_to_range_and_ascii
// Converts an echo pulse count to a Q10.6 centimetre distance, classes it
// against two threshold registers and renders it as six ASCII characters.
// ----------------------------------------------------------------------------
// The block has seven register stages (multiply, saturate, class and split,
// three decimal digit stages, text assembly with the output register), and
// each stage holds its item independently, so a new count is taken every
// cycle as long as the output is drained and a bubble anywhere in the pipe
// is filled even while a result waits at the output.
// The thresholds are written through the APB port at byte addresses 0x0
// (min_range) and 0x4 (max_range) and should be changed only while the
// pipeline is empty.
module echo_count_to_range_and_ascii (
    input  logic                         clk,
    input  logic                         rst_n,
    ecr_in_if.sink                       echo,
    ecr_out_if.source                    result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ecr_pkg::ADDR_W-1:0]   paddr,
    input  logic [ecr_pkg::DATA_W-1:0]   pwdata,
    output logic [ecr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int unsigned NS = ecr_pkg::NUM_STAGES;

    // Digit 0..9 to its ASCII character.
    function automatic logic [ecr_pkg::CHAR_W-1:0] to_ascii(input logic [3:0] d);
        return ecr_pkg::CH_ZERO | {4'h0, d};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ecr_pkg::DIST_W-1:0] min_range_reg;
    logic [ecr_pkg::DIST_W-1:0] max_range_reg;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg <= ecr_pkg::MIN_RANGE_RST;
            max_range_reg <= ecr_pkg::MAX_RANGE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ecr_pkg::REG_MIN_RANGE: min_range_reg <= pwdata[ecr_pkg::DIST_W-1:0];
                ecr_pkg::REG_MAX_RANGE: max_range_reg <= pwdata[ecr_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (paddr[2])
            ecr_pkg::REG_MIN_RANGE:
                prdata = {{(ecr_pkg::DATA_W-ecr_pkg::DIST_W){1'b0}}, min_range_reg};
            ecr_pkg::REG_MAX_RANGE:
                prdata = {{(ecr_pkg::DATA_W-ecr_pkg::DIST_W){1'b0}}, max_range_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or its
    // successor loads, so bubbles close up behind a stalled output.
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;
    logic [NS-1:0] valid_src;

    always_comb
    begin
        stage_en[NS-1] = !valid_reg[NS-1] || result.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_src = {valid_reg[NS-2:0], echo.valid};
        for (int k = 0; k < NS; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_src[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign echo.ready = stage_en[0];

    // ------------------------------------------------------------------
    // Stage 1: scale the count.
    // ------------------------------------------------------------------
    logic [ecr_pkg::PROD_W-1:0] s1_prod_reg;
    logic [ecr_pkg::PROD_W-1:0] s1_prod_next;

    assign s1_prod_next = ecr_pkg::PROD_W'(echo.echo_count) * ecr_pkg::SCALE;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s1_prod_reg <= s1_prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: drop the fraction bits of the scale and saturate.
    // ------------------------------------------------------------------
    logic [ecr_pkg::DIST_W:0]   s2_shift;
    logic [ecr_pkg::DIST_W-1:0] s2_dist_reg;
    logic [ecr_pkg::DIST_W-1:0] s2_dist_next;

    assign s2_shift     = s1_prod_reg[ecr_pkg::SCALE_SHIFT +: (ecr_pkg::DIST_W + 1)];
    assign s2_dist_next = s2_shift[ecr_pkg::DIST_W] ? '1 : s2_shift[ecr_pkg::DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s2_dist_reg <= s2_dist_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: range class, thousands digit, integer digit count and the
    // fraction scaled to thousandths.
    // ------------------------------------------------------------------
    logic [ecr_pkg::INT_W-1:0]  s3_ipart;
    logic [15:0]                s3_fprod;
    logic [ecr_pkg::DIST_W-1:0] s3_dist_reg;
    logic [ecr_pkg::CLS_W-1:0]  s3_cls_reg;
    logic [ecr_pkg::CLS_W-1:0]  s3_cls_next;
    logic                       s3_th_reg;
    logic                       s3_th_next;
    logic [1:0]                 s3_ndig_reg;
    logic [1:0]                 s3_ndig_next;
    logic [ecr_pkg::INT_W-1:0]  s3_irem_reg;
    logic [ecr_pkg::INT_W-1:0]  s3_irem_next;
    logic [9:0]                 s3_frac_reg;
    logic [9:0]                 s3_frac_next;

    assign s3_ipart = s2_dist_reg[ecr_pkg::DIST_W-1:ecr_pkg::FRAC_W];
    assign s3_fprod = 16'(s2_dist_reg[ecr_pkg::FRAC_W-1:0]) * 16'd1000;

    always_comb
    begin
        // Collision takes priority over above maximum.
        if (s2_dist_reg <= min_range_reg)
        begin
            s3_cls_next = ecr_pkg::CLS_COLLISION;
        end
        else if (s2_dist_reg >= max_range_reg)
        begin
            s3_cls_next = ecr_pkg::CLS_ABOVE;
        end
        else
        begin
            s3_cls_next = ecr_pkg::CLS_IN_RANGE;
        end

        s3_th_next   = (s3_ipart >= 10'd1000);
        s3_irem_next = s3_th_next ? (s3_ipart - 10'd1000) : s3_ipart;

        // Number of integer digits, minus one.
        if (s3_ipart >= 10'd1000)
        begin
            s3_ndig_next = 2'd3;
        end
        else if (s3_ipart >= 10'd100)
        begin
            s3_ndig_next = 2'd2;
        end
        else if (s3_ipart >= 10'd10)
        begin
            s3_ndig_next = 2'd1;
        end
        else
        begin
            s3_ndig_next = 2'd0;
        end

        s3_frac_next = s3_fprod[15:6];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_dist_reg <= s2_dist_reg;
            s3_cls_reg  <= s3_cls_next;
            s3_th_reg   <= s3_th_next;
            s3_ndig_reg <= s3_ndig_next;
            s3_irem_reg <= s3_irem_next;
            s3_frac_reg <= s3_frac_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: estimate the hundreds digits by multiplying with 41/4096.
    // ------------------------------------------------------------------
    logic [15:0]                s4_iprod;
    logic [15:0]                s4_fprod;
    logic [ecr_pkg::DIST_W-1:0] s4_dist_reg;
    logic [ecr_pkg::CLS_W-1:0]  s4_cls_reg;
    logic                       s4_th_reg;
    logic [1:0]                 s4_ndig_reg;
    logic [ecr_pkg::INT_W-1:0]  s4_irem_reg;
    logic [9:0]                 s4_frac_reg;
    logic [3:0]                 s4_ihq_reg;
    logic [3:0]                 s4_fhq_reg;

    assign s4_iprod = 16'(s3_irem_reg) * 16'd41;
    assign s4_fprod = 16'(s3_frac_reg) * 16'd41;

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            s4_dist_reg <= s3_dist_reg;
            s4_cls_reg  <= s3_cls_reg;
            s4_th_reg   <= s3_th_reg;
            s4_ndig_reg <= s3_ndig_reg;
            s4_irem_reg <= s3_irem_reg;
            s4_frac_reg <= s3_frac_reg;
            s4_ihq_reg  <= s4_iprod[15:12];
            s4_fhq_reg  <= s4_fprod[15:12];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: remainders below one hundred, correcting the estimate.
    // ------------------------------------------------------------------
    logic [10:0]                s5_irem_raw;
    logic [10:0]                s5_frem_raw;
    logic [10:0]                s5_irem_fix;
    logic [10:0]                s5_frem_fix;
    logic [3:0]                 s5_ihun_next;
    logic [3:0]                 s5_fhun_next;
    logic [ecr_pkg::DIST_W-1:0] s5_dist_reg;
    logic [ecr_pkg::CLS_W-1:0]  s5_cls_reg;
    logic                       s5_th_reg;
    logic [1:0]                 s5_ndig_reg;
    logic [3:0]                 s5_ihun_reg;
    logic [3:0]                 s5_fhun_reg;
    logic [6:0]                 s5_irem_reg;
    logic [6:0]                 s5_frem_reg;

    always_comb
    begin
        s5_irem_raw = 11'(s4_irem_reg) - 11'(s4_ihq_reg) * 11'd100;
        s5_frem_raw = 11'(s4_frac_reg) - 11'(s4_fhq_reg) * 11'd100;

        if (s5_irem_raw >= 11'd100)
        begin
            s5_ihun_next = s4_ihq_reg + 4'd1;
            s5_irem_fix  = s5_irem_raw - 11'd100;
        end
        else
        begin
            s5_ihun_next = s4_ihq_reg;
            s5_irem_fix  = s5_irem_raw;
        end

        if (s5_frem_raw >= 11'd100)
        begin
            s5_fhun_next = s4_fhq_reg + 4'd1;
            s5_frem_fix  = s5_frem_raw - 11'd100;
        end
        else
        begin
            s5_fhun_next = s4_fhq_reg;
            s5_frem_fix  = s5_frem_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            s5_dist_reg <= s4_dist_reg;
            s5_cls_reg  <= s4_cls_reg;
            s5_th_reg   <= s4_th_reg;
            s5_ndig_reg <= s4_ndig_reg;
            s5_ihun_reg <= s5_ihun_next;
            s5_fhun_reg <= s5_fhun_next;
            s5_irem_reg <= s5_irem_fix[6:0];
            s5_frem_reg <= s5_frem_fix[6:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: tens and ones; x * 205 >> 11 is exact for x below 100.
    // ------------------------------------------------------------------
    logic [14:0]                s6_itp;
    logic [14:0]                s6_ftp;
    logic [6:0]                 s6_ione;
    logic [6:0]                 s6_fone;
    logic [ecr_pkg::DIST_W-1:0] s6_dist_reg;
    logic [ecr_pkg::CLS_W-1:0]  s6_cls_reg;
    logic                       s6_th_reg;
    logic [1:0]                 s6_ndig_reg;
    logic [3:0]                 s6_ihun_reg;
    logic [3:0]                 s6_iten_reg;
    logic [3:0]                 s6_ione_reg;
    logic [3:0]                 s6_fhun_reg;
    logic [3:0]                 s6_ften_reg;
    logic [3:0]                 s6_fone_reg;

    assign s6_itp  = 15'(s5_irem_reg) * 15'd205;
    assign s6_ftp  = 15'(s5_frem_reg) * 15'd205;
    assign s6_ione = s5_irem_reg - 7'(s6_itp[14:11]) * 7'd10;
    assign s6_fone = s5_frem_reg - 7'(s6_ftp[14:11]) * 7'd10;

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            s6_dist_reg <= s5_dist_reg;
            s6_cls_reg  <= s5_cls_reg;
            s6_th_reg   <= s5_th_reg;
            s6_ndig_reg <= s5_ndig_reg;
            s6_ihun_reg <= s5_ihun_reg;
            s6_iten_reg <= s6_itp[14:11];
            s6_ione_reg <= s6_ione[3:0];
            s6_fhun_reg <= s5_fhun_reg;
            s6_ften_reg <= s6_ftp[14:11];
            s6_fone_reg <= s6_fone[3:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: place digits and the point into the text, output register.
    // ------------------------------------------------------------------
    logic [ecr_pkg::CHAR_W-1:0] d_th;
    logic [ecr_pkg::CHAR_W-1:0] d_ih;
    logic [ecr_pkg::CHAR_W-1:0] d_it;
    logic [ecr_pkg::CHAR_W-1:0] d_io;
    logic [ecr_pkg::CHAR_W-1:0] d_fh;
    logic [ecr_pkg::CHAR_W-1:0] d_ft;
    logic [ecr_pkg::CHAR_W-1:0] d_fo;
    logic [6*ecr_pkg::CHAR_W-1:0] text_next;
    logic [6*ecr_pkg::CHAR_W-1:0] text_reg;
    logic [ecr_pkg::DIST_W-1:0]   out_dist_reg;
    logic [ecr_pkg::CLS_W-1:0]    out_cls_reg;

    always_comb
    begin
        d_th = to_ascii({3'b000, s6_th_reg});
        d_ih = to_ascii(s6_ihun_reg);
        d_it = to_ascii(s6_iten_reg);
        d_io = to_ascii(s6_ione_reg);
        d_fh = to_ascii(s6_fhun_reg);
        d_ft = to_ascii(s6_ften_reg);
        d_fo = to_ascii(s6_fone_reg);

        // Character 0 sits in the top byte.
        case (s6_ndig_reg)
            2'd0:    text_next = {d_io, ecr_pkg::CH_DOT, d_fh, d_ft, d_fo, ecr_pkg::CH_ZERO};
            2'd1:    text_next = {d_it, d_io, ecr_pkg::CH_DOT, d_fh, d_ft, d_fo};
            2'd2:    text_next = {d_ih, d_it, d_io, ecr_pkg::CH_DOT, d_fh, d_ft};
            default: text_next = {d_th, d_ih, d_it, d_io, ecr_pkg::CH_DOT, d_fh};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            out_dist_reg <= s6_dist_reg;
            out_cls_reg  <= s6_cls_reg;
            text_reg     <= text_next;
        end
    end

    assign result.valid          = valid_reg[NS-1];
    assign result.distance_q10_6 = out_dist_reg;
    assign result.range_class    = out_cls_reg;
    assign result.char_0         = text_reg[47:40];
    assign result.char_1         = text_reg[39:32];
    assign result.char_2         = text_reg[31:24];
    assign result.char_3         = text_reg[23:16];
    assign result.char_4         = text_reg[15:8];
    assign result.char_5         = text_reg[7:0];

endmodule

// ===== rtl/ecr_checker.sv =====
// ----------------------------------------------------------------------------
// ecr_checker
// Port-level checks on the result channel of the echo range block.
// ----------------------------------------------------------------------------
`include "echo_count_to_range_and_ascii_assert.svh"

module ecr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [ecr_pkg::DIST_W-1:0]    distance_q10_6,
    input logic [ecr_pkg::CLS_W-1:0]     range_class,
    input logic [ecr_pkg::CHAR_W-1:0]    char_0,
    input logic [ecr_pkg::CHAR_W-1:0]    char_1,
    input logic [ecr_pkg::CHAR_W-1:0]    char_2,
    input logic [ecr_pkg::CHAR_W-1:0]    char_3,
    input logic [ecr_pkg::CHAR_W-1:0]    char_4,
    input logic [ecr_pkg::CHAR_W-1:0]    char_5
);

    // A stalled result stays offered, with its distance and first and last characters unchanged, until its transfer.
    `ECR_ASSERT_RST(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(distance_q10_6) && $stable(char_0) && $stable(char_5), "result changed while stalled")

    // Exactly one decimal point, never in the first or last position.
    `ECR_ASSERT_VALID(a_one_point, $onehot({char_1 == ecr_pkg::CH_DOT, char_2 == ecr_pkg::CH_DOT, char_3 == ecr_pkg::CH_DOT, char_4 == ecr_pkg::CH_DOT}) && char_0 != ecr_pkg::CH_DOT && char_5 != ecr_pkg::CH_DOT, "decimal point misplaced")

    // A leading zero appears only as the lone integer digit.
    `ECR_ASSERT_VALID(a_no_lead_zero, char_0 != ecr_pkg::CH_ZERO || char_1 == ecr_pkg::CH_DOT, "leading zero in integer part")

    // A thousand centimetres or more puts the point after four digits.
    `ECR_ASSERT_VALID(a_four_digits, distance_q10_6 < 16'd64000 || char_4 == ecr_pkg::CH_DOT, "point not after four digits")

    // Zero distance never exceeds the collision threshold.
    `ECR_ASSERT_VALID(a_zero_collide, distance_q10_6 != '0 || range_class == ecr_pkg::CLS_COLLISION, "zero distance not classed as collision")

endmodule

bind echo_count_to_range_and_ascii ecr_checker u_ecr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .distance_q10_6 (result.distance_q10_6),
    .range_class    (result.range_class),
    .char_0         (result.char_0),
    .char_1         (result.char_1),
    .char_2         (result.char_2),
    .char_3         (result.char_3),
    .char_4         (result.char_4),
    .char_5         (result.char_5)
);

// ===== tb/echo_count_to_range_and_ascii_tb.sv =====
// ----------------------------------------------------------------------------
// Echo count to range and ASCII testbench
// Sends echo counts through the valid/ready input channel and predicts each
// distance, range class and six-character text in a scoreboard class. Every
// result transfer is compared field by field against the oldest prediction.
// The thresholds are rewritten over APB between phases and read back, and the
// input and output sides idle and stall at several rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module echo_count_to_range_and_ascii_tb;

    import ecr_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned ITEMS_PER_PHASE = 160;
    localparam int unsigned BURST_ITEMS     = 40;
    localparam int unsigned NUM_PHASES      = 7;
    localparam int unsigned TEXT_LEN        = 6;
    localparam int unsigned FRAC_SCALE      = 1000;

    // Counts at the edges of the saturation, thousand-centimetre,
    // threshold and digit-count boundaries, plus bit patterns.
    localparam logic [CNT_W-1:0] CORNER_COUNTS [24] = '{
        16'd0, 16'd1, 16'd2, 16'd116, 16'd117, 16'd118,
        16'd583, 16'd584, 16'd5830, 16'd5831, 16'd23322, 16'd23323,
        16'd58306, 16'd58307, 16'd59704, 16'd59705, 16'd59706, 16'd65535,
        16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00
    };

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic [CLS_W-1:0]  range_class;
        logic [CHAR_W-1:0] text [TEXT_LEN];
    } echo_reading_t;

    // Predicts the reading for each accepted count and checks the results.
    class range_text_scoreboard;
        logic [DIST_W-1:0] min_thr;
        logic [DIST_W-1:0] max_thr;
        echo_reading_t     pending [$];
        int unsigned       errors;

        function new();
            min_thr = MIN_RANGE_RST;
            max_thr = MAX_RANGE_RST;
            errors  = 0;
        endfunction

        function void set_threshold(logic idx, logic [DIST_W-1:0] value);
            if (idx == REG_MIN_RANGE)
                min_thr = value;
            else
                max_thr = value;
        endfunction

        function echo_reading_t predict_reading(logic [CNT_W-1:0] count);
            echo_reading_t     r;
            logic [PROD_W-1:0] product;
            logic [PROD_W-1:0] scaled;
            int unsigned       whole;
            int unsigned       frac;
            int unsigned       digs [4];
            int unsigned       nd;
            int unsigned       pos;
            int unsigned       k;

            // Scale to Q10.6 centimetres and saturate.
            product = PROD_W'(count) * SCALE;
            scaled  = product >> SCALE_SHIFT;
            if (scaled > PROD_W'(16'hFFFF))
                r.distance = '1;
            else
                r.distance = scaled[DIST_W-1:0];

            // Collision takes precedence over above maximum.
            if (r.distance <= min_thr)
                r.range_class = CLS_COLLISION;
            else if (r.distance >= max_thr)
                r.range_class = CLS_ABOVE;
            else
                r.range_class = CLS_IN_RANGE;

            for (k = 0; k < TEXT_LEN; k++)
                r.text[k] = CH_ZERO;

            // Integer part without leading zeros, then the point.
            whole = r.distance[DIST_W-1:FRAC_W];
            frac  = (int'(r.distance[FRAC_W-1:0]) * FRAC_SCALE) >> FRAC_W;
            nd = 0;
            do begin
                digs[nd] = whole % 10;
                nd++;
                whole = whole / 10;
            end while (whole != 0 && nd < 4);
            pos = 0;
            while (nd > 0) begin
                nd--;
                r.text[pos] = CH_ZERO + CHAR_W'(digs[nd]);
                pos++;
            end
            r.text[pos] = CH_DOT;
            pos++;

            // Fraction digits, hundreds first, as far as the text reaches.
            digs[0] = frac / 100;
            digs[1] = (frac / 10) % 10;
            digs[2] = frac % 10;
            for (k = 0; k < 3 && pos < TEXT_LEN; k++) begin
                r.text[pos] = CH_ZERO + CHAR_W'(digs[k]);
                pos++;
            end
            return r;
        endfunction

        function void note_count(logic [CNT_W-1:0] count);
            pending.push_back(predict_reading(count));
        endfunction

        function void check_result(echo_reading_t got);
            echo_reading_t want;
            int unsigned   k;

            if (pending.size() == 0) begin
                $display("%0t: unexpected result, distance %0d", $time, got.distance);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.distance !== want.distance) begin
                $display("%0t: distance mismatch, expected %0d, actual %0d",
                         $time, want.distance, got.distance);
                errors++;
            end
            if (got.range_class !== want.range_class) begin
                $display("%0t: range class mismatch, expected %0d, actual %0d",
                         $time, want.range_class, got.range_class);
                errors++;
            end
            for (k = 0; k < TEXT_LEN; k++) begin
                if (got.text[k] !== want.text[k]) begin
                    $display("%0t: char_%0d mismatch, expected %h, actual %h",
                             $time, k, want.text[k], got.text[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    ecr_in_if  echo_if ();
    ecr_out_if result_if ();

    range_text_scoreboard sb;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;
    int unsigned          hold_request;
    int unsigned          cycle_count;

    echo_count_to_range_and_ascii uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .echo    (echo_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: check each transfer, then choose ready for the next cycle.
    // A requested hold-off is counted down here, one cycle per clock.
    always @(posedge clk)
    begin : result_sink
        echo_reading_t got;
        int unsigned   hold_left;

        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                got.distance    = result_if.distance_q10_6;
                got.range_class = result_if.range_class;
                got.text[0]     = result_if.char_0;
                got.text[1]     = result_if.char_1;
                got.text[2]     = result_if.char_2;
                got.text[3]     = result_if.char_3;
                got.text[4]     = result_if.char_4;
                got.text[5]     = result_if.char_5;
                sb.check_result(got);
            end
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [ADDR_W-1:0] reg_addr(logic idx);
        return {idx, 2'b00};
    endfunction

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic idx, input logic [DIST_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= {{(DATA_W-DIST_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_threshold(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic idx, output logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(idx);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read both thresholds back and compare them with the predicted copies.
    task automatic verify_thresholds();
        logic [DATA_W-1:0] data;

        apb_read(REG_MIN_RANGE, data);
        if (data !== {{(DATA_W-DIST_W){1'b0}}, sb.min_thr})
        begin
            $display("%0t: min_range readback, expected %h, actual %h",
                     $time, sb.min_thr, data);
            sb.errors++;
        end
        apb_read(REG_MAX_RANGE, data);
        if (data !== {{(DATA_W-DIST_W){1'b0}}, sb.max_thr})
        begin
            $display("%0t: max_range readback, expected %h, actual %h",
                     $time, sb.max_thr, data);
            sb.errors++;
        end
    endtask

    // Offer one count, idling first at the current rate; valid stays high
    // after the transfer so that back-to-back items keep it asserted.
    task automatic send_count(input logic [CNT_W-1:0] count);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            echo_if.valid <= 1'b0;
            @(posedge clk);
        end
        echo_if.valid      <= 1'b1;
        echo_if.echo_count <= count;
        do @(posedge clk); while (!echo_if.ready);
        sb.note_count(count);
    endtask

    // Wait for every predicted result, then for the pipeline to settle.
    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    // Mix of full-range, short, near-saturation and near-threshold counts.
    function automatic logic [CNT_W-1:0] random_count();
        int c;
        int thr;

        case ($urandom_range(0, 3))
            0: c = $urandom_range(0, 65535);
            1: c = $urandom_range(0, 1023);
            2: c = $urandom_range(56000, 65535);
            default:
            begin
                thr = $urandom_range(0, 1) ? int'(sb.min_thr) : int'(sb.max_thr);
                c = thr * 1024 / 1124 + int'($urandom_range(0, 6)) - 3;
                if (c < 0)
                    c = 0;
                if (c > 65535)
                    c = 65535;
            end
        endcase
        return c[CNT_W-1:0];
    endfunction

    // Main sequence: reset, corner counts, then random phases.
    initial
    begin : stimulus
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        logic [DIST_W-1:0] tmp;
        int unsigned       p;
        int unsigned       i;

        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        echo_if.valid      <= 1'b0;
        echo_if.echo_count <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        verify_thresholds();

        for (i = 0; i < 24; i++)
            send_count(CORNER_COUNTS[i]);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // New thresholds, extremes and crossed settings among them.
            if (p != 0)
            begin
                case (p)
                    1: begin lo = 16'h0000; hi = 16'hFFFF; end
                    2: begin lo = 16'hFFFF; hi = 16'h0000; end
                    3: begin lo = 16'h0000; hi = 16'h0000; end
                    4: begin lo = 16'hFFFF; hi = 16'hFFFF; end
                    5:
                    begin
                        lo = $urandom_range(0, 65535);
                        hi = $urandom_range(0, 65535);
                        if (lo > hi)
                        begin
                            tmp = lo;
                            lo  = hi;
                            hi  = tmp;
                        end
                    end
                    default:
                    begin
                        lo = $urandom_range(0, 65535);
                        hi = $urandom_range(0, 65535);
                    end
                endcase
                wait_drained();
                apb_write(REG_MIN_RANGE, lo);
                apb_write(REG_MAX_RANGE, hi);
                verify_thresholds();
            end

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase

            // Long receiver hold-off while counts keep coming, so the
            // pipeline fills and the input stalls.
            if (p == 4)
            begin
                hold_request = HOLD_OFF_CYCLES;
                repeat (BURST_ITEMS) send_count(random_count());
            end

            repeat (ITEMS_PER_PHASE) send_count(random_count());
            echo_if.valid <= 1'b0;
        end

        wait_drained();
        repeat (2 * NUM_STAGES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
